FILE: sv/bsa_pkg.sv
// Shared types and codes for the bounding sphere accumulator.
package bsa_pkg;

  typedef logic [2:0] func_t;
  localparam func_t FN_RESET    = 3'd0;
  localparam func_t FN_GROW_PT  = 3'd1;
  localparam func_t FN_GROW_SPH = 3'd2;
  localparam func_t FN_OVERLAP  = 3'd3;
  localparam func_t FN_GROWTH   = 3'd4;

  // result select: A is the sphere being grown, B the one grown by
  typedef enum logic [1:0] {
    RES_KEEP_A,
    RES_COPY_B,
    RES_POINT_B,
    RES_LARGER
  } res_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_SQ_GO,
    S_SQ_WAIT,
    S_CHECK,
    S_SQRT_GO,
    S_SQRT_WAIT,
    S_GROW,
    S_MV_MUL_GO,
    S_MV_MUL_WAIT,
    S_MV_DIV_GO,
    S_MV_DIV_WAIT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic     load;
    logic     mul_start;
    logic     mul_move;
    logic [1:0] axis;
    logic     sq_acc;
    logic     sqrt_start;
    logic     sqrt_store;
    logic     set_grow;
    logic     div_start;
    logic     move_store;
    logic     res_write;
    res_sel_t res_sel;
    logic     ovl_write;
    logic     finish;
  } bsa_cmd_t;

  typedef struct packed {
    func_t func;
    logic  a_neg;
    logic  b_neg;
    logic  mul_done;
    logic  sqrt_done;
    logic  div_done;
    logic  rt_ge_d2;
    logic  dist_zero;
  } bsa_stat_t;

endpackage

FILE: sv/bsa_mul.sv
// Iterative unsigned multiplier, DIG bits of the second operand per cycle.
module bsa_mul #(
  parameter int MW = 33
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MW-1:0]     op_a,
  input  logic [MW-1:0]     op_b,
  output logic [2*MW-1:0]   prod,
  output logic              done
);
  localparam int PW    = 2 * MW;
  localparam int DIG   = 8;
  localparam int NSTEP = (MW + DIG - 1) / DIG;
  localparam int CW    = $clog2(NSTEP + 1);

  logic [PW-1:0]     a_r;
  logic [MW-1:0]     b_r;
  logic [PW-1:0]     acc_r;
  logic [CW-1:0]     cnt_r;
  logic              busy_r, done_r;
  logic [PW+DIG-1:0] part;

  assign part = a_r * b_r[DIG-1:0];
  assign prod = acc_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NSTEP);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r   <= {{MW{1'b0}}, op_a};
      b_r   <= op_b;
      acc_r <= '0;
    end else if (busy_r) begin
      acc_r <= acc_r + part[PW-1:0];
      a_r   <= a_r << DIG;
      b_r   <= b_r >> DIG;
    end
  end

endmodule

FILE: sv/bsa_sqrt.sv
// Bit-serial integer square root, floor(sqrt(n)), one root bit per cycle.
module bsa_sqrt #(
  parameter int MW = 33
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*MW-1:0] n,
  output logic [MW-1:0]   root,
  output logic            done
);
  localparam int CW = $clog2(MW + 1);

  logic [2*MW-1:0] n_r;
  logic [MW-1:0]   root_r;
  logic [MW+1:0]   rem_r;
  logic [CW-1:0]   cnt_r;
  logic            busy_r, done_r;
  logic [MW+3:0]   rem2, trial;
  logic            take;

  assign rem2  = {rem_r, n_r[2*MW-1 -: 2]};
  assign trial = {2'b00, root_r, 2'b01};
  assign take  = (rem2 >= trial);
  assign root  = root_r;
  assign done  = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r    <= n;
      root_r <= '0;
      rem_r  <= '0;
    end else if (busy_r) begin
      n_r    <= n_r << 2;
      root_r <= {root_r[MW-2:0], take};
      rem_r  <= take ? (MW+2)'(rem2 - trial) : rem2[MW+1:0];
    end
  end

endmodule

FILE: sv/bsa_div.sv
// Restoring divider; the quotient is known to fit in MW bits.
module bsa_div #(
  parameter int MW = 33
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*MW-1:0] num,
  input  logic [MW-1:0]   den,
  output logic [MW-1:0]   quo,
  output logic            done
);
  localparam int CW = $clog2(MW + 1);

  logic [MW-1:0] rem_r, nq_r, den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [MW:0]   rem2;
  logic          take;

  assign rem2 = {rem_r, nq_r[MW-1]};
  assign take = (rem2 >= {1'b0, den_r});
  assign quo  = nq_r;
  assign done = done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(MW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // low dividend bits shift out the top while quotient bits shift in
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num[2*MW-1:MW];
      nq_r  <= num[MW-1:0];
      den_r <= den;
    end else if (busy_r) begin
      rem_r <= take ? MW'(rem2 - {1'b0, den_r}) : rem2[MW-1:0];
      nq_r  <= {nq_r[MW-2:0], take};
    end
  end

endmodule

FILE: sv/bsa_datapath.sv
// Datapath: stored sphere, operands, arithmetic units and output registers.
module bsa_datapath
  import bsa_pkg::*;
#(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [2:0]          in_func,
  input  logic signed [W-1:0] in_x,
  input  logic signed [W-1:0] in_y,
  input  logic signed [W-1:0] in_z,
  input  logic signed [W-1:0] in_radius,
  input  bsa_cmd_t            cmd,
  output bsa_stat_t           stat,
  output logic signed [W-1:0] out_center_x,
  output logic signed [W-1:0] out_center_y,
  output logic signed [W-1:0] out_center_z,
  output logic signed [W-1:0] out_sphere_radius,
  output logic                out_overlaps,
  output logic signed [W-1:0] out_growth
);
  localparam int MW = W + 1;
  localparam int PW = 2 * MW;

  function automatic logic [W-1:0] sat(input logic [W+1:0] v);
    logic [W-1:0] r;
    if (v[W+1:W-1] == 3'b000 || v[W+1:W-1] == 3'b111) r = v[W-1:0];
    else if (v[W+1]) r = {1'b1, {(W-1){1'b0}}};
    else r = {1'b0, {(W-1){1'b1}}};
    return r;
  endfunction

  function automatic logic [W:0] mag(input logic [W:0] v);
    return v[W] ? (~v + 1'b1) : v;
  endfunction

  logic [W-1:0] st_c_r [3];
  logic [W-1:0] st_r_r;
  logic [W-1:0] a_c_r [3];
  logic [W-1:0] b_c_r [3];
  logic [W-1:0] a_r_r, b_r_r;
  logic [W-1:0] res_c_r [3];
  logic [W-1:0] res_r_r;
  func_t        func_r;
  logic [PW-1:0] d2_r, rt_r;
  logic [MW-1:0] dist_r, g_r;
  logic          ovl_r;
  logic [W-1:0]  oc_r [3];
  logic [W-1:0]  or_r, og_r;
  logic          oo_r;

  logic [W:0]    dd [3];
  logic [W:0]    dmag [3];
  logic [W:0]    rterm;
  logic [MW-1:0] mul_a, mul_b, sqrt_root, quo;
  logic [PW-1:0] prod;
  logic          mul_done, sqrt_done, div_done;
  logic [W:0]    g_pt, nr, g_sp, g;
  logic [W+1:0]  sum3, rsum, mv, gdiff;
  logic          a_lt_b, upd;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dd[i]   = {b_c_r[i][W-1], b_c_r[i]} - {a_c_r[i][W-1], a_c_r[i]};
      dmag[i] = mag(dd[i]);
    end
  end

  always_comb begin
    unique case (func_r)
      FN_GROW_PT: rterm = {1'b0, a_r_r};
      FN_OVERLAP: rterm = {1'b0, a_r_r} + {1'b0, b_r_r};
      default:    rterm = mag({b_r_r[W-1], b_r_r} - {a_r_r[W-1], a_r_r});
    endcase
  end

  always_comb begin
    if (cmd.mul_move) begin
      mul_a = dmag[cmd.axis];
      mul_b = g_r;
    end else if (cmd.axis == 2'd3) begin
      mul_a = rterm;
      mul_b = rterm;
    end else begin
      mul_a = dmag[cmd.axis];
      mul_b = dmag[cmd.axis];
    end
  end

  bsa_mul #(.MW(MW)) u_mul (
    .clk(clk), .rst_n(rst_n), .start(cmd.mul_start),
    .op_a(mul_a), .op_b(mul_b), .prod(prod), .done(mul_done)
  );

  bsa_sqrt #(.MW(MW)) u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(cmd.sqrt_start),
    .n(d2_r), .root(sqrt_root), .done(sqrt_done)
  );

  bsa_div #(.MW(MW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_start),
    .num(prod), .den(dist_r), .quo(quo), .done(div_done)
  );

  // growth of the radius: point grow vs sphere merge
  assign g_pt  = (dist_r - {1'b0, a_r_r}) >> 1;
  assign sum3  = {2'b00, a_r_r} + {2'b00, b_r_r} + {1'b0, dist_r};
  assign nr    = sum3[W+1:1];
  assign g_sp  = nr - {1'b0, a_r_r};
  assign g     = (func_r == FN_GROW_PT) ? g_pt : g_sp;
  assign rsum  = {2'b00, a_r_r} + {1'b0, g};
  assign mv    = dd[cmd.axis][W]
                 ? {{2{a_c_r[cmd.axis][W-1]}}, a_c_r[cmd.axis]} - {1'b0, quo}
                 : {{2{a_c_r[cmd.axis][W-1]}}, a_c_r[cmd.axis]} + {1'b0, quo};
  assign gdiff = {{2{res_r_r[W-1]}}, res_r_r} - {{2{b_r_r[W-1]}}, b_r_r};
  assign a_lt_b = $signed(a_r_r) < $signed(b_r_r);
  assign upd   = (func_r == FN_RESET) || (func_r == FN_GROW_PT) ||
                 (func_r == FN_GROW_SPH);

  assign stat.func      = func_r;
  assign stat.a_neg     = a_r_r[W-1];
  assign stat.b_neg     = b_r_r[W-1];
  assign stat.mul_done  = mul_done;
  assign stat.sqrt_done = sqrt_done;
  assign stat.div_done  = div_done;
  assign stat.rt_ge_d2  = (rt_r >= d2_r);
  assign stat.dist_zero = (dist_r == '0);

  // stored sphere
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) st_c_r[i] <= '0;
      st_r_r <= '1;
    end else if (cmd.finish && upd) begin
      for (int i = 0; i < 3; i++) st_c_r[i] <= res_c_r[i];
      st_r_r <= res_r_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      d2_r   <= '0;
      ovl_r  <= 1'b0;
      if (in_func == FN_GROWTH) begin
        a_c_r[0] <= in_x; a_c_r[1] <= in_y; a_c_r[2] <= in_z; a_r_r <= in_radius;
        for (int i = 0; i < 3; i++) b_c_r[i] <= st_c_r[i];
        b_r_r <= st_r_r;
      end else begin
        b_c_r[0] <= in_x; b_c_r[1] <= in_y; b_c_r[2] <= in_z; b_r_r <= in_radius;
        for (int i = 0; i < 3; i++) a_c_r[i] <= st_c_r[i];
        a_r_r <= st_r_r;
      end
    end
    if (cmd.sq_acc) begin
      if (cmd.axis == 2'd3) rt_r <= prod;
      else d2_r <= d2_r + prod;
    end
    if (cmd.ovl_write) ovl_r <= (rt_r > d2_r);
    if (cmd.sqrt_store) dist_r <= sqrt_root;
    if (cmd.res_write) begin
      unique case (cmd.res_sel)
        RES_KEEP_A: begin
          for (int i = 0; i < 3; i++) res_c_r[i] <= a_c_r[i];
          res_r_r <= a_r_r;
        end
        RES_COPY_B: begin
          for (int i = 0; i < 3; i++) res_c_r[i] <= b_c_r[i];
          res_r_r <= b_r_r;
        end
        RES_POINT_B: begin
          for (int i = 0; i < 3; i++) res_c_r[i] <= b_c_r[i];
          res_r_r <= '0;
        end
        RES_LARGER: begin
          for (int i = 0; i < 3; i++) res_c_r[i] <= a_lt_b ? b_c_r[i] : a_c_r[i];
          res_r_r <= a_lt_b ? b_r_r : a_r_r;
        end
      endcase
    end
    if (cmd.set_grow) begin
      g_r <= g;
      for (int i = 0; i < 3; i++) res_c_r[i] <= a_c_r[i];
      res_r_r <= sat(rsum);
    end
    if (cmd.move_store) res_c_r[cmd.axis] <= sat(mv);
    if (cmd.finish) begin
      for (int i = 0; i < 3; i++) oc_r[i] <= upd ? res_c_r[i] : st_c_r[i];
      or_r <= upd ? res_r_r : st_r_r;
      oo_r <= ovl_r;
      og_r <= (func_r == FN_GROWTH) ? sat(gdiff) : '0;
    end
  end

  assign out_center_x      = oc_r[0];
  assign out_center_y      = oc_r[1];
  assign out_center_z      = oc_r[2];
  assign out_sphere_radius = or_r;
  assign out_overlaps      = oo_r;
  assign out_growth        = og_r;

endmodule

FILE: sv/bsa_ctrl.sv
// Controller: sequences the arithmetic units and owns both handshakes.
module bsa_ctrl
  import bsa_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  bsa_stat_t stat,
  output bsa_cmd_t  cmd
);
  state_t     state_r, state_nxt;
  logic [1:0] k_r, k_nxt;
  logic       ov_r, ov_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      k_r     <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      k_r     <= k_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  always_comb begin
    state_nxt = state_r;
    k_nxt     = k_r;
    ov_nxt    = ov_r && !out_ready;
    cmd       = '0;
    cmd.axis  = k_r;
    cmd.res_sel = RES_KEEP_A;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        k_nxt = '0;
        state_nxt = S_DONE;
        priority case (stat.func)
          FN_RESET: begin
            cmd.res_write = 1'b1;
            cmd.res_sel   = RES_POINT_B;
          end
          FN_GROW_PT: begin
            if (stat.a_neg) begin
              cmd.res_write = 1'b1;
              cmd.res_sel   = RES_POINT_B;
            end else state_nxt = S_SQ_GO;
          end
          FN_GROW_SPH, FN_GROWTH: begin
            if (stat.b_neg) cmd.res_write = 1'b1;
            else if (stat.a_neg) begin
              cmd.res_write = 1'b1;
              cmd.res_sel   = RES_COPY_B;
            end else state_nxt = S_SQ_GO;
          end
          FN_OVERLAP: begin
            if (stat.a_neg || stat.b_neg) cmd.res_write = 1'b1;
            else state_nxt = S_SQ_GO;
          end
          default: cmd.res_write = 1'b1;
        endcase
      end
      S_SQ_GO: begin
        cmd.mul_start = 1'b1;
        state_nxt = S_SQ_WAIT;
      end
      S_SQ_WAIT: begin
        if (stat.mul_done) begin
          cmd.sq_acc = 1'b1;
          if (k_r == 2'd3) state_nxt = S_CHECK;
          else begin
            k_nxt = k_r + 1'b1;
            state_nxt = S_SQ_GO;
          end
        end
      end
      S_CHECK: begin
        state_nxt = S_DONE;
        if (stat.func == FN_OVERLAP) begin
          cmd.ovl_write = 1'b1;
          cmd.res_write = 1'b1;
        end else if (stat.rt_ge_d2) begin
          // inside or contained: no merge
          cmd.res_write = 1'b1;
          cmd.res_sel   = (stat.func == FN_GROW_PT) ? RES_KEEP_A : RES_LARGER;
        end else state_nxt = S_SQRT_GO;
      end
      S_SQRT_GO: begin
        cmd.sqrt_start = 1'b1;
        state_nxt = S_SQRT_WAIT;
      end
      S_SQRT_WAIT: begin
        if (stat.sqrt_done) begin
          cmd.sqrt_store = 1'b1;
          state_nxt = S_GROW;
        end
      end
      S_GROW: begin
        cmd.set_grow = 1'b1;
        k_nxt = '0;
        state_nxt = stat.dist_zero ? S_DONE : S_MV_MUL_GO;
      end
      S_MV_MUL_GO: begin
        cmd.mul_start = 1'b1;
        cmd.mul_move  = 1'b1;
        state_nxt = S_MV_MUL_WAIT;
      end
      S_MV_MUL_WAIT: begin
        cmd.mul_move = 1'b1;
        if (stat.mul_done) state_nxt = S_MV_DIV_GO;
      end
      S_MV_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt = S_MV_DIV_WAIT;
      end
      S_MV_DIV_WAIT: begin
        if (stat.div_done) begin
          cmd.move_store = 1'b1;
          if (k_r == 2'd2) state_nxt = S_DONE;
          else begin
            k_nxt = k_r + 1'b1;
            state_nxt = S_MV_MUL_GO;
          end
        end
      end
      S_DONE: begin
        if (!ov_r || out_ready) begin
          cmd.finish = 1'b1;
          ov_nxt     = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: sv/bounding_sphere_accumulator_top.sv
// Bounding sphere accumulator: one request at a time, one result per request.
// Reset, empty and unused-code requests skip the arithmetic; overlap tests and
//   contained spheres run only the squared-distance multiplies; a full merge
//   adds a square root and three multiply+divide passes.
// The arithmetic uses the shared 8-bit-per-cycle multiplier, bit-serial sqrt and divider.
// Sync active-low reset: center 0, radius -1 (empty), no result pending.
module bounding_sphere_accumulator_top
  import bsa_pkg::*;
#(
  parameter int COORD_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_func,
  input  logic signed [COORD_WIDTH-1:0] in_x,
  input  logic signed [COORD_WIDTH-1:0] in_y,
  input  logic signed [COORD_WIDTH-1:0] in_z,
  input  logic signed [COORD_WIDTH-1:0] in_radius,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [COORD_WIDTH-1:0] out_center_x,
  output logic signed [COORD_WIDTH-1:0] out_center_y,
  output logic signed [COORD_WIDTH-1:0] out_center_z,
  output logic signed [COORD_WIDTH-1:0] out_sphere_radius,
  output logic                          out_overlaps,
  output logic signed [COORD_WIDTH-1:0] out_growth
);
  bsa_cmd_t  cmd;
  bsa_stat_t stat;

  bsa_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready),
    .stat(stat), .cmd(cmd)
  );

  bsa_datapath #(.W(COORD_WIDTH)) u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_func(in_func), .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .in_radius(in_radius),
    .cmd(cmd), .stat(stat),
    .out_center_x(out_center_x), .out_center_y(out_center_y),
    .out_center_z(out_center_z), .out_sphere_radius(out_sphere_radius),
    .out_overlaps(out_overlaps), .out_growth(out_growth)
  );

endmodule

FILE: sv/bsa_checker.sv
// Port-level checks for the bounding sphere accumulator, bound to the top.
module bsa_checker #(
  parameter int COORD_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [COORD_WIDTH-1:0] out_sphere_radius,
  input logic                   out_overlaps,
  input logic [COORD_WIDTH-1:0] out_growth
);
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  a_overlap_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_overlaps |-> !out_sphere_radius[COORD_WIDTH-1])
    else $error("overlap reported for empty sphere");

  a_growth_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_growth != '0) |-> !out_overlaps)
    else $error("growth and overlap in one result");
endmodule

bind bounding_sphere_accumulator_top bsa_checker #(.COORD_WIDTH(COORD_WIDTH)) u_bsa_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready),
  .out_sphere_radius(out_sphere_radius), .out_overlaps(out_overlaps),
  .out_growth(out_growth)
);
